// ===== rtl/cle_pkg.sv =====
// Shared constants and types for the console line editor.
`default_nettype none

package cle_pkg;

  // Byte codes with a special meaning in line mode
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOKED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_CAP    = 2'd2;

  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_EDIT   = 4'b0100,
    ST_DRAIN  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/console_line_editor.sv =====
// Console line editor: line accumulation, editing and echo over a line memory.
//
// Channels:
//   s_axis takes one input byte per transaction. Each byte causes zero or
//   more result transactions on m_axis: an optional echo byte (tdata[7:0],
//   flagged by tuser[0]) and an optional delivered byte (tdata[15:8],
//   flagged by tuser[1]; tuser[2] marks the final byte of a line). tlast
//   marks the last result caused by one input byte. Write configuration
//   (line mode, echo, line capacity) through cfg_* only while idle.
// Sequencing:
//   A byte is accepted in the idle state and decoded in the decode state once
//   the output register is free; a raw or echoed stored byte enters it there.
//   An echoed erase gives three results from the edit state; a line end gives
//   N results (at most LINE_MAX) from the drain state, one memory read per
//   result, so the single read port sets the drain rate. A new byte waits for idle.
// Reset:
//   Line mode and echo on, capacity 64, empty line. The line memory is not
//   cleared; only entries written in the current line are ever read.
// Backpressure:
//   Hold the sequencer while m_axis_tready is low; nothing is dropped or repeated.
`default_nettype none

module console_line_editor #(
  parameter int unsigned LINE_MAX = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [cle_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cle_pkg::CAP_W-1:0]    cfg_data_i,
  // Input stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // [7:0] in_byte
  // Result stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [15:0]                       m_axis_tdata,   // [7:0] echo_byte, [15:8] line_byte
  output logic [2:0]                        m_axis_tuser,   // [0] echo_valid, [1] line_valid,
                                                            // [2] line_end
  output logic                              m_axis_tlast    // last
);

  localparam int unsigned AW    = $clog2(LINE_MAX);
  localparam int unsigned LEN_W = $clog2(LINE_MAX + 1);
  localparam int unsigned NW    = LEN_W + 1;  // room for counts up to LINE_MAX + 2

  // Configuration registers
  logic                      cooked_q;
  logic                      echo_en_q;
  logic [cle_pkg::CAP_W-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooked_q  <= 1'b1;
      echo_en_q <= 1'b1;
      cap_q     <= cle_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cle_pkg::CFG_COOKED:      cooked_q  <= cfg_data_i[0];
        cle_pkg::CFG_ECHO_ENABLE: echo_en_q <= cfg_data_i[0];
        cle_pkg::CFG_LINE_CAP:    cap_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp capacity into 1..LINE_MAX
  logic [NW-1:0] cap_eff;
  always_comb begin
    if (cap_q > cle_pkg::CAP_W'(LINE_MAX)) begin
      cap_eff = NW'(LINE_MAX);
    end else if (cap_q == '0) begin
      cap_eff = NW'(1);
    end else begin
      cap_eff = NW'(cap_q);
    end
  end

  // Control state
  cle_pkg::state_e state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [NW-1:0]    idx_q, idx_d;       // result counter within one input
  logic [NW-1:0]    stored_q, stored_d; // bytes read from the memory in a drain
  logic [NW-1:0]    n_q, n_d;           // delivered bytes in a drain
  logic [NW-1:0]    total_q, total_d;   // results in a drain
  logic [7:0]       in_q;

  // Output register
  logic       ovalid_q, ovalid_d;
  logic [7:0] oecho_q, oecho_d, oline_q, oline_d;
  logic       oev_q, oev_d, olv_q, olv_d, ole_q, ole_d, olast_q, olast_d;
  logic       out_free;

  // Line memory
  logic [7:0]    line_mem [LINE_MAX];
  logic [7:0]    rdata_q;
  logic          mem_we;
  logic [NW-1:0] rd_next;
  logic [AW-1:0] rd_addr;

  // Decode helpers
  logic          is_erase, is_eol, has_room;
  logic [NW-1:0] len_ext, stored_c, n_c, ne_c, tot_c;

  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == cle_pkg::ST_IDLE);

  assign is_erase = (in_q == cle_pkg::CH_DEL) || (in_q == cle_pkg::CH_BS);
  assign is_eol   = (in_q == cle_pkg::CH_CR) || (in_q == cle_pkg::CH_LF);
  assign len_ext  = NW'(len_q);
  assign has_room = ((len_ext + NW'(2)) < cap_eff) && (len_ext < NW'(LINE_MAX));

  always_comb begin
    stored_c = (len_ext < cap_eff) ? len_ext : cap_eff;
    n_c      = ((stored_c + NW'(2)) < cap_eff) ? (stored_c + NW'(2)) : cap_eff;
    ne_c     = echo_en_q ? NW'(2) : NW'(0);
    tot_c    = (n_c > ne_c) ? n_c : ne_c;
  end

  // Keep the read data aligned with idx_q while draining
  assign rd_next = ((state_q == cle_pkg::ST_DRAIN) && out_free) ? (idx_q + NW'(1)) : idx_q;
  assign rd_addr = rd_next[AW-1:0];

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    idx_d    = idx_q;
    stored_d = stored_q;
    n_d      = n_q;
    total_d  = total_q;
    mem_we   = 1'b0;
    ovalid_d = ovalid_q && !m_axis_tready;
    oecho_d  = oecho_q;
    oline_d  = oline_q;
    oev_d    = oev_q;
    olv_d    = olv_q;
    ole_d    = ole_q;
    olast_d  = olast_q;

    case (state_q)
      cle_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = cle_pkg::ST_DECODE;
        end
      end

      cle_pkg::ST_DECODE: begin
        if (out_free) begin
          state_d = cle_pkg::ST_IDLE;
          idx_d   = '0;
          if (!cooked_q) begin
            // Raw: pass the byte through as a one-byte line
            ovalid_d = 1'b1;
            oev_d    = echo_en_q;
            oecho_d  = echo_en_q ? in_q : 8'h00;
            olv_d    = 1'b1;
            oline_d  = in_q;
            ole_d    = 1'b1;
            olast_d  = 1'b1;
          end else if (is_erase) begin
            if (len_q != '0) begin
              len_d = len_q - LEN_W'(1);
              if (echo_en_q) begin
                state_d = cle_pkg::ST_EDIT;
              end
            end
          end else if (is_eol) begin
            // Snapshot the line shape and start the drain
            stored_d = stored_c;
            n_d      = n_c;
            total_d  = tot_c;
            len_d    = '0;
            state_d  = cle_pkg::ST_DRAIN;
          end else if (has_room) begin
            mem_we = 1'b1;
            len_d  = len_q + LEN_W'(1);
            if (echo_en_q) begin
              ovalid_d = 1'b1;
              oev_d    = 1'b1;
              oecho_d  = in_q;
              olv_d    = 1'b0;
              oline_d  = 8'h00;
              ole_d    = 1'b0;
              olast_d  = 1'b1;
            end
          end
        end
      end

      cle_pkg::ST_EDIT: begin
        // Echo BS SP BS
        if (out_free) begin
          ovalid_d = 1'b1;
          oev_d    = 1'b1;
          oecho_d  = (idx_q == NW'(1)) ? cle_pkg::CH_SP : cle_pkg::CH_BS;
          olv_d    = 1'b0;
          oline_d  = 8'h00;
          ole_d    = 1'b0;
          olast_d  = (idx_q == NW'(2));
          if (idx_q == NW'(2)) begin
            idx_d   = '0;
            state_d = cle_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + NW'(1);
          end
        end
      end

      cle_pkg::ST_DRAIN: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          oev_d    = echo_en_q && (idx_q < NW'(2));
          oecho_d  = !oev_d ? 8'h00 : ((idx_q == '0) ? cle_pkg::CH_CR : cle_pkg::CH_LF);
          olv_d    = idx_q < n_q;
          if (!olv_d) begin
            oline_d = 8'h00;
          end else if (idx_q < stored_q) begin
            oline_d = rdata_q;
          end else if (idx_q == stored_q) begin
            oline_d = cle_pkg::CH_CR;
          end else begin
            oline_d = cle_pkg::CH_LF;
          end
          ole_d   = olv_d && ((idx_q + NW'(1)) == n_q);
          olast_d = (idx_q + NW'(1)) == total_q;
          if (olast_d) begin
            idx_d   = '0;
            state_d = cle_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + NW'(1);
          end
        end
      end

      default: begin
        state_d = cle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cle_pkg::ST_IDLE;
      len_q    <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= s_axis_tdata;
    end
    stored_q <= stored_d;
    n_q      <= n_d;
    total_q  <= total_d;
    oecho_q  <= oecho_d;
    oline_q  <= oline_d;
    oev_q    <= oev_d;
    olv_q    <= olv_d;
    ole_q    <= ole_d;
    olast_q  <= olast_d;
  end

  // Line memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[len_q[AW-1:0]] <= in_q;
    end
    rdata_q <= line_mem[rd_addr];
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {oline_q, oecho_q};
  assign m_axis_tuser  = {ole_q, olv_q, oev_q};
  assign m_axis_tlast  = olast_q;

  // Assertions
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(len_q) <= NW'(LINE_MAX))
    else $error("line length above LINE_MAX");

  a_drain_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cle_pkg::ST_DRAIN) |-> (idx_q < total_q))
    else $error("drain index past result count");

  a_drain_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cle_pkg::ST_DRAIN) |-> (len_q == '0 && stored_q <= n_q))
    else $error("line not cleared or bad shape during drain");

  a_edit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cle_pkg::ST_EDIT) |-> (idx_q <= NW'(2)))
    else $error("erase echo counter out of range");

endmodule

`default_nettype wire

// ===== bench/tb_console_line_editor.sv =====
// Self-checking testbench for the console line editor: directed edits, line ends and raw bytes.
`timescale 1ns / 100ps

module tb_console_line_editor;

  localparam int unsigned LINE_MAX     = 64;
  localparam int unsigned CYCLE_LIMIT  = 600_000;
  // An item with no result returns the block to idle from the decode state;
  // leave margin before any register write.
  localparam int unsigned IDLE_SETTLE  = 16;
  // A full line end drains up to LINE_MAX results; wait past that at the end.
  localparam int unsigned END_SETTLE   = 80;
  localparam int unsigned NUM_PHASES   = 9;
  localparam int unsigned PHASE_ITEMS  = 45;
  // Register index with no register behind it; writes there must do nothing.
  localparam logic [cle_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // One result transaction, in the order of the fields on m_axis.
  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       line_end;
    logic       closes_input;
  } cle_result_t;

  // Mirror of the editor: its own copy of the line and registers, and the
  // results each accepted byte is due to produce.
  class line_editor_mirror;
    logic [7:0]               stored_line [LINE_MAX];
    int unsigned              stored_len;
    bit                       cooked;
    bit                       echo_on;
    logic [cle_pkg::CAP_W-1:0] capacity_reg;
    cle_result_t              due_results [$];
    int unsigned              mismatches;
    int unsigned              results_seen;
    int unsigned              keys_seen;
    int unsigned              lines_delivered;

    function new();
      cooked       = 1'b1;
      echo_on      = 1'b1;
      capacity_reg = cle_pkg::CAP_RESET;
      stored_len   = 0;
    endfunction

    function void write_reg(logic [cle_pkg::CFG_IDX_W-1:0] idx, logic [cle_pkg::CAP_W-1:0] val);
      case (idx)
        cle_pkg::CFG_COOKED:      cooked       = val[0];
        cle_pkg::CFG_ECHO_ENABLE: echo_on      = val[0];
        cle_pkg::CFG_LINE_CAP:    capacity_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned eff_capacity();
      int unsigned c;
      c = capacity_reg;
      if (c > LINE_MAX) c = LINE_MAX;
      if (c == 0) c = 1;
      return c;
    endfunction

    function void queue_result(bit ev, logic [7:0] eb, bit lv, logic [7:0] lb, bit le, bit cl);
      cle_result_t r;
      r.echo_valid   = ev;
      r.echo_byte    = ev ? eb : 8'h00;
      r.line_valid   = lv;
      r.line_byte    = lv ? lb : 8'h00;
      r.line_end     = lv && le;
      r.closes_input = cl;
      due_results.push_back(r);
    endfunction

    // Note one accepted byte; return 1 unless the editor ignores it.
    function bit apply_key(logic [7:0] key);
      int unsigned cap;
      int unsigned keep;
      int unsigned n_echo;
      int unsigned total;
      logic [7:0]  outgoing [$];
      cap = eff_capacity();
      keys_seen++;
      if (!cooked) begin
        queue_result(echo_on, key, 1'b1, key, 1'b1, 1'b1);
        return 1'b1;
      end
      if (key == cle_pkg::CH_DEL || key == cle_pkg::CH_BS) begin
        if (stored_len == 0) return 1'b0;
        stored_len--;
        if (echo_on) begin
          queue_result(1'b1, cle_pkg::CH_BS, 1'b0, 8'h00, 1'b0, 1'b0);
          queue_result(1'b1, cle_pkg::CH_SP, 1'b0, 8'h00, 1'b0, 1'b0);
          queue_result(1'b1, cle_pkg::CH_BS, 1'b0, 8'h00, 1'b0, 1'b1);
        end
        return 1'b1;
      end
      if (key == cle_pkg::CH_CR || key == cle_pkg::CH_LF) begin
        // Deliver the stored bytes, then CR LF, all cut to the capacity.
        keep = (stored_len < cap) ? stored_len : cap;
        for (int i = 0; i < keep; i++) outgoing.push_back(stored_line[i]);
        if (outgoing.size() < cap) outgoing.push_back(cle_pkg::CH_CR);
        if (outgoing.size() < cap) outgoing.push_back(cle_pkg::CH_LF);
        n_echo = echo_on ? 2 : 0;
        total  = (outgoing.size() > n_echo) ? outgoing.size() : n_echo;
        for (int i = 0; i < total; i++) begin
          queue_result(i < n_echo, (i == 0) ? cle_pkg::CH_CR : cle_pkg::CH_LF,
                       i < outgoing.size(), (i < outgoing.size()) ? outgoing[i] : 8'h00,
                       i + 1 == outgoing.size(), i + 1 == total);
        end
        stored_len = 0;
        lines_delivered++;
        return 1'b1;
      end
      if (stored_len + 2 < cap && stored_len < LINE_MAX) begin
        stored_line[stored_len] = key;
        stored_len++;
        if (echo_on) queue_result(1'b1, key, 1'b0, 8'h00, 1'b0, 1'b1);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(logic [15:0] data, logic [2:0] user, logic tail);
      cle_result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing pending: tdata 0x%0h tuser 0x%0h tlast %0b",
               data, user, tail);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      results_seen++;
      check_field("echo_valid", want.echo_valid, user[0]);
      check_field("echo_byte", want.echo_byte, data[7:0]);
      check_field("line_valid", want.line_valid, user[1]);
      check_field("line_byte", want.line_byte, data[15:8]);
      check_field("line_end", want.line_end, user[2]);
      check_field("last", want.closes_input, tail);
    endfunction
  endclass

  // Drive every input to a known value from time zero.
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [cle_pkg::CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [cle_pkg::CAP_W-1:0]     cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [15:0]                   m_axis_tdata;           // [7:0] echo_byte, [15:8] line_byte
  logic [2:0]                    m_axis_tuser;           // [0] echo_valid, [1] line_valid,
                                                         // [2] line_end
  logic                          m_axis_tlast;

  line_editor_mirror mirror;
  int unsigned       src_idle_pct   = 15;
  int unsigned       sink_stall_pct = 76;
  int unsigned       sent_items     = 0;
  int unsigned       settings_count = 0;
  int unsigned       cycle_count    = 0;

  // Phase settings: line mode, echo, raw capacity value.
  bit         phase_mode [NUM_PHASES] = '{1, 1, 0, 1, 1, 0, 1, 1, 1};
  bit         phase_echo [NUM_PHASES] = '{1, 1, 1, 0, 1, 0, 1, 1, 1};
  logic [6:0] phase_cap  [NUM_PHASES] = '{7'd64, 7'd6, 7'd64, 7'd24, 7'd127,
                                          7'd9, 7'd2, 7'd64, 7'd40};

  console_line_editor #(
    .LINE_MAX (LINE_MAX)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog: give up well past the slowest legal run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results still pending",
             cycle_count, mirror.due_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: stall at random on each falling edge, at the current rate.
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Check every result transaction at the rising edge that moves it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      mirror.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Present one byte, idling first at random, and hold it until accepted.
  task automatic send_byte(input logic [7:0] key);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    void'(mirror.apply_key(key));
    sent_items++;
  endtask

  // Drop valid, wait for every pending result, then let the block settle.
  task automatic drain(input int unsigned settle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Raise one register write for the next rising edge; the caller drops the enable.
  task automatic put_reg(input logic [cle_pkg::CFG_IDX_W-1:0] idx,
                         input logic [cle_pkg::CAP_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    mirror.write_reg(idx, val);
  endtask

  task automatic set_cfg(input bit mode, input bit echo, input logic [6:0] cap);
    drain(IDLE_SETTLE);
    put_reg(cle_pkg::CFG_COOKED, {6'd0, mode});
    put_reg(cle_pkg::CFG_ECHO_ENABLE, {6'd0, echo});
    put_reg(cle_pkg::CFG_LINE_CAP, cap);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  // Type one line: mostly printable keys, some erases and some arbitrary
  // bytes, now and then long enough to overflow; close with CR or LF.
  task automatic type_line();
    int unsigned n_keys;
    int unsigned roll;
    n_keys = ($urandom_range(9) == 0) ? $urandom_range(72, 40) : $urandom_range(14, 0);
    repeat (n_keys) begin
      roll = $urandom_range(99);
      if (roll < 12)
        send_byte($urandom_range(1) ? cle_pkg::CH_BS : cle_pkg::CH_DEL);
      else if (roll < 18)
        send_byte(8'($urandom_range(255)));
      else
        send_byte(8'($urandom_range(8'h7E, 8'h20)));
    end
    send_byte($urandom_range(1) ? cle_pkg::CH_CR : cle_pkg::CH_LF);
  endtask

  initial begin
    int unsigned target;
    mirror = new();

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings (line mode, echo on, capacity 64).
    send_byte(cle_pkg::CH_DEL);          // erase on an empty line
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(cle_pkg::CH_BS);
    send_byte(cle_pkg::CH_DEL);
    send_byte(cle_pkg::CH_CR);           // deliver the one byte left
    send_byte(cle_pkg::CH_LF);           // line end on an empty line

    // Echo off, capacity 3: one byte fits, the next is dropped, edits are silent.
    set_cfg(1'b1, 1'b0, 7'd3);
    put_reg(CFG_SPARE_IDX, 7'h55);       // write to an unused index: no effect
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    send_byte(8'h78);
    send_byte(8'h79);
    send_byte(cle_pkg::CH_BS);
    send_byte(cle_pkg::CH_CR);

    // Capacity 0 acts as 1: nothing stored, a line end delivers CR alone.
    set_cfg(1'b1, 1'b1, 7'd0);
    send_byte(8'h7A);
    send_byte(cle_pkg::CH_LF);

    // Capacity above the maximum acts as the maximum; then lower it mid-line.
    set_cfg(1'b1, 1'b1, 7'd127);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    send_byte(8'h64);
    set_cfg(1'b1, 1'b1, 7'd4);
    send_byte(cle_pkg::CH_CR);           // four stored bytes, no room for CR LF

    // Raw mode leaves the stored line alone; it resumes in line mode.
    set_cfg(1'b1, 1'b1, 7'd64);
    send_byte(8'h71);
    set_cfg(1'b0, 1'b1, 7'd64);
    send_byte(cle_pkg::CH_CR);
    send_byte(cle_pkg::CH_DEL);
    set_cfg(1'b1, 1'b0, 7'd2);
    send_byte(cle_pkg::CH_CR);

    // Random phases: three settings per idle profile, heavy receiver stalls
    // first, then heavy sender idling, then a stretch with no idling.
    sent_items = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p / 3)
        0:       begin src_idle_pct = 15; sink_stall_pct = 76; end
        1:       begin src_idle_pct = 76; sink_stall_pct = 15; end
        default: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      endcase
      set_cfg(phase_mode[p], phase_echo[p], phase_cap[p]);
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        if (phase_mode[p]) type_line();
        else send_byte(8'($urandom_range(255)));
      end
    end

    // Wait for every pending result, then for stray ones past the longest drain.
    drain(END_SETTLE);
    if (mirror.due_results.size() != 0) begin
      $error("%0d expected results never arrived", mirror.due_results.size());
      mirror.mismatches++;
    end

    $display("Run: %0d input bytes over %0d register settings, line and raw mode, echo on/off",
             mirror.keys_seen, settings_count);
    $display("Run: %0d results checked, %0d lines delivered, %0d mismatches",
             mirror.results_seen, mirror.lines_delivered, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
